@@ hdl/rstu_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rstu_pkg: shared types, constants and helpers
// Sample and result payloads, stage records and the calendar tables of the
// cmos rtc sample to unix time converter.
// ----------------------------------------------------------------------------
package rstu_pkg;

  // status b bit positions
  localparam int SB_INHIBIT_BIT = 7;
  localparam int SB_BINARY_BIT  = 2;
  localparam int SB_H24_BIT     = 1;

  // result status codes
  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_INVALID = 2'd1;
  localparam logic [1:0] ST_RANGE   = 2'd2;

  localparam logic [14:0] YEAR_MIN     = 15'd1970;
  localparam logic [13:0] YEAR_CAP     = 14'd9999;
  localparam logic [13:0] MAX_YEAR_RST = 14'd2099;

  typedef struct packed {
    logic [7:0] mode_status;
    logic [7:0] second_byte;
    logic [7:0] minute_byte;
    logic [7:0] hour_byte;
    logic [7:0] weekday_byte;
    logic [7:0] day_byte;
    logic [7:0] month_byte;
    logic [7:0] year_byte;
    logic [7:0] century_byte;
  } sample_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [13:0] year_out;
    logic [3:0]  month_out;
    logic [4:0]  day_out;
    logic [4:0]  hour_out;
    logic [5:0]  minute_out;
    logic [5:0]  second_out;
    logic [2:0]  weekday_out;
    logic [37:0] unix_seconds;
  } result_t;

  // decoded sample, after the first stage
  typedef struct packed {
    logic       early_bad;
    logic [7:0] sec;
    logic [7:0] min;
    logic [4:0] hour;
    logic [7:0] wd;
    logic [7:0] day;
    logic [7:0] mon;
    logic [7:0] yr;
    logic [7:0] cen;
  } dec_t;

  // checked calendar fields and day count
  typedef struct packed {
    logic [1:0]  status;
    logic [13:0] year;
    logic [3:0]  mon;
    logic [4:0]  day;
    logic [4:0]  hour;
    logic [5:0]  min;
    logic [5:0]  sec;
    logic [2:0]  wd;
    logic [21:0] days;
    logic [16:0] tod;
  } cal_t;

  function automatic logic bcd_ok(input logic [7:0] b);
    return (b[7:4] <= 4'd9) && (b[3:0] <= 4'd9);
  endfunction

  function automatic logic [7:0] bcd_val(input logic [7:0] b);
    logic [7:0] hi;
    hi = {4'd0, b[7:4]};
    return (hi << 3) + (hi << 1) + {4'd0, b[3:0]};
  endfunction

  // days before the first of month m (1..12), common year
  function automatic logic [8:0] days_before(input logic [3:0] m);
    logic [8:0] d;
    case (m)
      4'd1:    d = 9'd0;
      4'd2:    d = 9'd31;
      4'd3:    d = 9'd59;
      4'd4:    d = 9'd90;
      4'd5:    d = 9'd120;
      4'd6:    d = 9'd151;
      4'd7:    d = 9'd181;
      4'd8:    d = 9'd212;
      4'd9:    d = 9'd243;
      4'd10:   d = 9'd273;
      4'd11:   d = 9'd304;
      4'd12:   d = 9'd334;
      default: d = 9'd0;
    endcase
    return d;
  endfunction

  // length of month m (1..12), common year
  function automatic logic [4:0] month_len(input logic [3:0] m);
    logic [4:0] d;
    case (m)
      4'd2:    d = 5'd28;
      4'd4:    d = 5'd30;
      4'd6:    d = 5'd30;
      4'd9:    d = 5'd30;
      4'd11:   d = 5'd30;
      default: d = 5'd31;
    endcase
    return d;
  endfunction

endpackage
`default_nettype wire

@@ hdl/rstu_decode.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rstu_decode: raw register decode stage
// Bcd or binary decode of the raw bytes, 12/24-hour conversion and the
// inhibit, digit and hour checks.
// ----------------------------------------------------------------------------
module rstu_decode (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  input  rstu_pkg::sample_t sample,
  output logic            out_valid,
  output rstu_pkg::dec_t  dec
);
  import rstu_pkg::*;

  logic       inhibit, binary, h24, pm;
  logic [7:0] hr_raw;
  logic       digits_bad, hour_bad;
  logic [7:0] hr_v;
  logic [4:0] hour12;
  dec_t       dec_next;

  always_comb begin
    inhibit = sample.mode_status[SB_INHIBIT_BIT];
    binary  = sample.mode_status[SB_BINARY_BIT];
    h24     = sample.mode_status[SB_H24_BIT];
    pm      = sample.hour_byte[7];
    hr_raw  = {1'b0, sample.hour_byte[6:0]};

    digits_bad = !(bcd_ok(sample.second_byte) && bcd_ok(sample.minute_byte) &&
                   bcd_ok(hr_raw) && bcd_ok(sample.weekday_byte) &&
                   bcd_ok(sample.day_byte) && bcd_ok(sample.month_byte) &&
                   bcd_ok(sample.year_byte) && bcd_ok(sample.century_byte));

    dec_next.sec = binary ? sample.second_byte  : bcd_val(sample.second_byte);
    dec_next.min = binary ? sample.minute_byte  : bcd_val(sample.minute_byte);
    hr_v         = binary ? hr_raw              : bcd_val(hr_raw);
    dec_next.wd  = binary ? sample.weekday_byte : bcd_val(sample.weekday_byte);
    dec_next.day = binary ? sample.day_byte     : bcd_val(sample.day_byte);
    dec_next.mon = binary ? sample.month_byte   : bcd_val(sample.month_byte);
    dec_next.yr  = binary ? sample.year_byte    : bcd_val(sample.year_byte);
    dec_next.cen = binary ? sample.century_byte : bcd_val(sample.century_byte);

    // twelve o'clock am is hour zero, pm adds twelve
    hour12 = ((hr_v == 8'd12) ? 5'd0 : hr_v[4:0]) + (pm ? 5'd12 : 5'd0);
    if (h24) begin
      hour_bad      = pm || (hr_v > 8'd23);
      dec_next.hour = hr_v[4:0];
    end else begin
      hour_bad      = (hr_v == 8'd0) || (hr_v > 8'd12);
      dec_next.hour = hour12;
    end

    dec_next.early_bad = inhibit || (!binary && digits_bad) || hour_bad;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    dec <= dec_next;
  end

endmodule
`default_nettype wire

@@ hdl/rstu_calendar.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rstu_calendar: year, range, leap and day count stages
// Three stages: full year and field checks, range check with the /100
// reciprocal product, then leap year, day of month check and day count.
// ----------------------------------------------------------------------------
module rstu_calendar (
  input  logic           clk,
  input  logic           rst,
  input  logic [13:0]    max_year,
  input  logic           in_valid,
  input  rstu_pkg::dec_t dec,
  output logic           out_valid,
  output rstu_pkg::cal_t cal
);
  import rstu_pkg::*;

  typedef struct packed {
    logic        early_bad;
    logic        field_bad;
    logic [14:0] year;
    logic [3:0]  mon;
    logic [4:0]  day;
    logic [4:0]  hour;
    logic [5:0]  min;
    logic [5:0]  sec;
    logic [2:0]  wd;
  } yr_t;

  typedef struct packed {
    logic        early_bad;
    logic        field_bad;
    logic        range_bad;
    logic [14:0] year;
    logic [14:0] ym1;
    logic [27:0] prod;
    logic [21:0] yoff365;
    logic [8:0]  dbm;
    logic [4:0]  mlen;
    logic [3:0]  mon;
    logic [4:0]  day;
    logic [4:0]  hour;
    logic [5:0]  min;
    logic [5:0]  sec;
    logic [2:0]  wd;
  } rng_t;

  logic  s2_valid, s3_valid;
  yr_t   s2, s2_next;
  rng_t  s3, s3_next;
  cal_t  cal_next;

  logic [13:0] limit;
  logic [12:0] yoff;
  logic [8:0]  qm;
  logic [14:0] rm_full;
  logic [6:0]  rm;
  logic        leap, day_bad;
  logic [4:0]  dim;

  // full year and the checks that need no year
  always_comb begin
    s2_next.early_bad = dec.early_bad;
    // a day above 31 would wrap in the five-bit field, so it is caught here
    s2_next.field_bad = (dec.mon == 8'd0) || (dec.mon > 8'd12) || (dec.day == 8'd0) ||
                        (dec.day > 8'd31) ||
                        (dec.min > 8'd59) || (dec.sec > 8'd59) ||
                        (dec.wd == 8'd0) || (dec.wd > 8'd7);
    s2_next.year = ({7'd0, dec.cen} * 15'd100) + {7'd0, dec.yr};
    s2_next.mon  = dec.mon[3:0];
    s2_next.day  = dec.day[4:0];
    s2_next.hour = dec.hour;
    s2_next.min  = dec.min[5:0];
    s2_next.sec  = dec.sec[5:0];
    s2_next.wd   = dec.wd[2:0];
  end

  // range check, year offset product and (year - 1) / 100 reciprocal
  always_comb begin
    limit = (max_year > YEAR_CAP) ? YEAR_CAP : max_year;
    yoff  = 13'(s2.year - YEAR_MIN);
    s3_next.early_bad = s2.early_bad;
    s3_next.field_bad = s2.field_bad;
    s3_next.range_bad = (s2.year < YEAR_MIN) || (s2.year > {1'b0, limit});
    s3_next.year    = s2.year;
    s3_next.ym1     = s2.year - 15'd1;
    s3_next.prod    = {13'd0, s3_next.ym1} * 28'd5243;
    s3_next.yoff365 = {9'd0, yoff} * 22'd365;
    s3_next.dbm     = days_before(s2.mon);
    s3_next.mlen    = month_len(s2.mon);
    s3_next.mon     = s2.mon;
    s3_next.day     = s2.day;
    s3_next.hour    = s2.hour;
    s3_next.min     = s2.min;
    s3_next.sec     = s2.sec;
    s3_next.wd      = s2.wd;
  end

  // leap year, day of month check, day count since the epoch
  always_comb begin
    qm      = s3.prod[27:19];
    rm_full = s3.ym1 - ({6'd0, qm} * 15'd100);
    rm      = rm_full[6:0];
    // year % 100 == 0 exactly when (year - 1) % 100 == 99
    leap    = (s3.year[1:0] == 2'b00) && ((rm != 7'd99) || (qm[1:0] == 2'b11));
    dim     = (s3.mon == 4'd2 && leap) ? 5'd29 : s3.mlen;
    day_bad = s3.day > dim;

    if (s3.early_bad) begin
      cal_next.status = ST_INVALID;
    end else if (s3.range_bad) begin
      cal_next.status = ST_RANGE;
    end else if (s3.field_bad || day_bad) begin
      cal_next.status = ST_INVALID;
    end else begin
      cal_next.status = ST_OK;
    end

    // leaps through 1969 is 477, and one more for day - 1
    cal_next.days = s3.yoff365 + {9'd0, s3.ym1[14:2]} + {15'd0, qm[8:2]} +
                    {13'd0, s3.dbm} + {21'd0, (leap && s3.mon > 4'd2)} +
                    {17'd0, s3.day} - {13'd0, qm} - 22'd478;
    cal_next.tod  = ({12'd0, s3.hour} * 17'd3600) + ({11'd0, s3.min} * 17'd60) +
                    {11'd0, s3.sec};
    cal_next.year = s3.year[13:0];
    cal_next.mon  = s3.mon;
    cal_next.day  = s3.day;
    cal_next.hour = s3.hour;
    cal_next.min  = s3.min;
    cal_next.sec  = s3.sec;
    cal_next.wd   = s3.wd;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid  <= 1'b0;
      s3_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      s2_valid  <= in_valid;
      s3_valid  <= s2_valid;
      out_valid <= s3_valid;
    end
  end

  always_ff @(posedge clk) begin
    s2  <= s2_next;
    s3  <= s3_next;
    cal <= cal_next;
  end

endmodule
`default_nettype wire

@@ hdl/rstu_epoch.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rstu_epoch: seconds since the epoch and result register
// Day count times 86400 in one stage, time of day added and failed
// samples zeroed in the output stage.
// ----------------------------------------------------------------------------
module rstu_epoch (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  input  rstu_pkg::cal_t    cal,
  output logic              out_valid,
  output rstu_pkg::result_t result
);
  import rstu_pkg::*;

  logic        s5_valid;
  cal_t        s5;
  logic [38:0] day_secs, day_secs_next;
  logic [37:0] secs;
  result_t     result_next;

  assign day_secs_next = {17'd0, cal.days} * 39'd86400;

  always_comb begin
    secs = day_secs[37:0] + {21'd0, s5.tod};
    result_next = '0;
    result_next.status = s5.status;
    if (s5.status == ST_OK) begin
      result_next.year_out     = s5.year;
      result_next.month_out    = s5.mon;
      result_next.day_out      = s5.day;
      result_next.hour_out     = s5.hour;
      result_next.minute_out   = s5.min;
      result_next.second_out   = s5.sec;
      result_next.weekday_out  = s5.wd;
      result_next.unix_seconds = secs;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s5_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      s5_valid  <= in_valid;
      out_valid <= s5_valid;
    end
  end

  always_ff @(posedge clk) begin
    s5       <= cal;
    day_secs <= day_secs_next;
    result   <= result_next;
  end

endmodule
`default_nettype wire

@@ hdl/rtc_sample_to_unix_time_core.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rtc_sample_to_unix_time_core: cmos rtc sample to unix seconds
// Decodes one raw rtc register sample into checked calendar fields and the
// seconds elapsed since 1970-01-01 00:00:00.
// ----------------------------------------------------------------------------
// A sample is taken on every clock edge where start is high and busy is low;
// busy is high only while rst is asserted, so one sample can be started in
// every cycle. Each sample comes back as a result with done high for a
// single cycle; there is no way to hold results off, so the receiver must
// take every transfer as it comes. The result passes through six register
// stages: decode, full year, range check with the /100 reciprocal product,
// leap and day count, the 86400 multiply, and the final add into the result
// register. cfg_ready is always high; max_year should only be written while
// no sample is in flight.
// ----------------------------------------------------------------------------
module rtc_sample_to_unix_time_core (
  input  logic              clk,
  input  logic              rst,
  // sample channel
  input  logic              start,
  output logic              busy,
  input  rstu_pkg::sample_t sample,
  // max_year register write
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [13:0]       cfg_data,
  // result channel
  output logic              done,
  output rstu_pkg::result_t result
);
  import rstu_pkg::*;

  logic [13:0] max_year_reg;
  logic        in_valid;
  logic        dec_valid, cal_valid;
  dec_t        dec;
  cal_t        cal;

  // samples are refused only during reset
  assign busy      = rst;
  assign cfg_ready = 1'b1;
  assign in_valid  = start && !busy;

  // year limit register, written by a config transfer
  always_ff @(posedge clk) begin
    if (rst) begin
      max_year_reg <= MAX_YEAR_RST;
    end else if (cfg_valid && cfg_ready) begin
      max_year_reg <= cfg_data;
    end
  end

  // stage 1: byte decode and hour handling
  rstu_decode u_decode (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .sample    (sample),
    .out_valid (dec_valid),
    .dec       (dec)
  );

  // stages 2 to 4: year, range, leap, day count
  rstu_calendar u_calendar (
    .clk       (clk),
    .rst       (rst),
    .max_year  (max_year_reg),
    .in_valid  (dec_valid),
    .dec       (dec),
    .out_valid (cal_valid),
    .cal       (cal)
  );

  // stages 5 and 6: epoch seconds and result register
  rstu_epoch u_epoch (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (cal_valid),
    .cal       (cal),
    .out_valid (done),
    .result    (result)
  );

endmodule
`default_nettype wire

@@ tb/rtc_check_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rtc_check_pkg: expected-result tracking for the rtc sample converter
// Holds a calendar predictor for one raw rtc sample and the queue of results
// still owed by the block, checked field by field as they come out.
// ----------------------------------------------------------------------------
package rtc_check_pkg;
  import rstu_pkg::*;

  class rtc_result_tracker;
    logic [13:0] max_year = MAX_YEAR_RST;
    result_t     owed_results[$];
    int          errors;
    int          samples_seen;
    int          n_ok;
    int          n_invalid;
    int          n_range;

    static function bit gregorian_leap(int unsigned y);
      return (y % 4 == 0) && ((y % 100 != 0) || (y % 400 == 0));
    endfunction

    static function int unsigned month_days(int unsigned y, int unsigned m);
      case (m)
        2:          return gregorian_leap(y) ? 29 : 28;
        4, 6, 9, 11: return 30;
        default:    return 31;
      endcase
    endfunction

    // leap years in 1..y
    static function longint unsigned leaps_upto(int unsigned y);
      return longint'(y / 4) - longint'(y / 100) + longint'(y / 400);
    endfunction

    function result_t convert(sample_t s);
      result_t         r;
      logic [7:0]      raw [8];
      int unsigned     v [8];
      bit              pm;
      int unsigned     hr;
      int unsigned     year;
      int unsigned     lim;
      longint unsigned days;
      int              i;
      r = '0;
      pm = s.hour_byte[7];
      raw[0] = s.second_byte;
      raw[1] = s.minute_byte;
      raw[2] = {1'b0, s.hour_byte[6:0]};
      raw[3] = s.weekday_byte;
      raw[4] = s.day_byte;
      raw[5] = s.month_byte;
      raw[6] = s.year_byte;
      raw[7] = s.century_byte;
      if (s.mode_status[SB_INHIBIT_BIT]) begin
        r.status = ST_INVALID;
        return r;
      end
      for (i = 0; i < 8; i++) begin
        if (s.mode_status[SB_BINARY_BIT]) begin
          v[i] = raw[i];
        end else if (raw[i][7:4] > 9 || raw[i][3:0] > 9) begin
          r.status = ST_INVALID;
          return r;
        end else begin
          v[i] = raw[i][7:4] * 10 + raw[i][3:0];
        end
      end
      if (s.mode_status[SB_H24_BIT]) begin
        if (pm || v[2] > 23) begin
          r.status = ST_INVALID;
          return r;
        end
        hr = v[2];
      end else begin
        if (v[2] == 0 || v[2] > 12) begin
          r.status = ST_INVALID;
          return r;
        end
        hr = v[2] % 12 + (pm ? 12 : 0);
      end
      year = v[7] * 100 + v[6];
      lim = (max_year > YEAR_CAP) ? YEAR_CAP : max_year;
      if (year < YEAR_MIN || year > lim) begin
        r.status = ST_RANGE;
        return r;
      end
      if (v[5] == 0 || v[5] > 12 || v[4] == 0 || v[4] > month_days(year, v[5]) ||
          hr > 23 || v[1] > 59 || v[0] > 59 || v[3] == 0 || v[3] > 7) begin
        r.status = ST_INVALID;
        return r;
      end
      days = longint'(year - YEAR_MIN) * 365 + leaps_upto(year - 1) -
             leaps_upto(YEAR_MIN - 1);
      for (i = 1; i < v[5]; i++)
        days += month_days(year, i);
      days += v[4] - 1;
      r.status       = ST_OK;
      r.year_out     = 14'(year);
      r.month_out    = 4'(v[5]);
      r.day_out      = 5'(v[4]);
      r.hour_out     = 5'(hr);
      r.minute_out   = 6'(v[1]);
      r.second_out   = 6'(v[0]);
      r.weekday_out  = 3'(v[3]);
      r.unix_seconds = 38'(days * 86400 + hr * 3600 + v[1] * 60 + v[0]);
      return r;
    endfunction

    function void set_limit(logic [13:0] v);
      max_year = v;
    endfunction

    function void note_sample(sample_t s);
      result_t r;
      r = convert(s);
      samples_seen++;
      case (r.status)
        ST_OK:      n_ok++;
        ST_INVALID: n_invalid++;
        default:    n_range++;
      endcase
      owed_results.push_back(r);
    endfunction

    function int pending();
      return owed_results.size();
    endfunction

    function bit field_ok(string name, longint unsigned e, longint unsigned a);
      if (e != a)
        $display("%0t: %s mismatch, expected %0d actual %0d", $time, name, e, a);
      return e == a;
    endfunction

    function void check_result(result_t r);
      result_t e;
      bit      ok;
      if (owed_results.size() == 0) begin
        $display("%0t: unexpected result, expected none actual %h", $time, r);
        errors++;
        return;
      end
      e = owed_results.pop_front();
      ok = 1'b1;
      ok &= field_ok("status", e.status, r.status);
      ok &= field_ok("year_out", e.year_out, r.year_out);
      ok &= field_ok("month_out", e.month_out, r.month_out);
      ok &= field_ok("day_out", e.day_out, r.day_out);
      ok &= field_ok("hour_out", e.hour_out, r.hour_out);
      ok &= field_ok("minute_out", e.minute_out, r.minute_out);
      ok &= field_ok("second_out", e.second_out, r.second_out);
      ok &= field_ok("weekday_out", e.weekday_out, r.weekday_out);
      ok &= field_ok("unix_seconds", e.unix_seconds, r.unix_seconds);
      if (!ok)
        errors++;
    endfunction
  endclass

endpackage

@@ tb/tb_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: testbench of the rtc sample to unix time converter
// Drives directed corner samples and then a long random mix of well-formed
// dates, single-fault samples and raw noise across several max_year
// settings, predicting every result and checking it field by field.
// ----------------------------------------------------------------------------
module tb_top;
  import rstu_pkg::*;
  import rtc_check_pkg::*;

  localparam int CYCLE_LIMIT = 200000;
  localparam int PHASE_ITEMS = 190;

  // status b mode bits
  localparam logic [7:0] M_H24 = 8'(1 << SB_H24_BIT);
  localparam logic [7:0] M_BIN = 8'(1 << SB_BINARY_BIT);
  localparam logic [7:0] M_INH = 8'(1 << SB_INHIBIT_BIT);
  localparam logic [7:0] MODE_BCD24 = M_H24;
  localparam logic [7:0] MODE_BCD12 = 8'h00;
  localparam logic [7:0] MODE_BIN24 = M_BIN | M_H24;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        start = 1'b0;
  logic        cfg_valid = 1'b0;
  logic [13:0] cfg_data = '0;
  sample_t     sample = '0;
  logic        busy;
  logic        cfg_ready;
  logic        done;
  result_t     result;

  rtc_result_tracker tracker = new();

  int          cycle_cnt = 0;
  int          taken_cnt = 0;   // sample transfers seen
  int          cfg_cnt = 0;     // max_year transfers seen
  int          settings_cnt = 1;
  logic [13:0] cur_limit = MAX_YEAR_RST;

  rtc_sample_to_unix_time_core dut (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .busy      (busy),
    .sample    (sample),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data),
    .done      (done),
    .result    (result)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  // all handshakes are observed here at the rising edge; inputs only move at
  // the falling edge, so what is seen is what the block registers
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (!rst) begin
      // the result leaving now belongs to the oldest sample still owed
      if (done)
        tracker.check_result(result);
      if (start && !busy) begin
        tracker.note_sample(sample);
        taken_cnt <= taken_cnt + 1;
      end
      if (cfg_valid && cfg_ready) begin
        tracker.set_limit(cfg_data);
        cfg_cnt <= cfg_cnt + 1;
      end
    end
  end

  // watchdog
  initial begin
    while (cycle_cnt < CYCLE_LIMIT)
      @(posedge clk);
    $display("timeout after %0d cycles", cycle_cnt);
    $display("TB_ERROR");
    $finish;
  end

  function automatic int unsigned eff_limit();
    return (cur_limit > YEAR_CAP) ? YEAR_CAP : cur_limit;
  endfunction

  // register encoding of a value, bcd or plain binary
  function automatic logic [7:0] enc(int unsigned v, bit bin);
    return bin ? 8'(v) : 8'(((v / 10) << 4) | (v % 10));
  endfunction

  // a date that passes every check under the current limit (when it can)
  function automatic sample_t good_sample();
    sample_t     s;
    bit          bin;
    bit          h24;
    int unsigned lim;
    int unsigned y;
    int unsigned m;
    int unsigned d;
    int unsigned h;
    int unsigned h12;
    lim = eff_limit();
    bin = 1'($urandom_range(0, 1));
    h24 = 1'($urandom_range(0, 1));
    if (lim < YEAR_MIN)
      y = $urandom_range(YEAR_MIN, 2099);
    else if ($urandom_range(0, 1))
      y = $urandom_range(YEAR_MIN, (lim < 2199) ? lim : 2199);
    else
      y = $urandom_range(YEAR_MIN, lim);
    m = $urandom_range(1, 12);
    d = rtc_result_tracker::month_days(y, m);
    // lean on month ends, where leap handling matters
    d = $urandom_range(0, 2) ? $urandom_range(1, d) : d - $urandom_range(0, 1);
    h = $urandom_range(0, 23);
    h12 = (h % 12 == 0) ? 12 : h % 12;
    s.mode_status = 8'($urandom);
    s.mode_status[SB_INHIBIT_BIT] = 1'b0;
    s.mode_status[SB_BINARY_BIT] = bin;
    s.mode_status[SB_H24_BIT] = h24;
    s.second_byte = enc($urandom_range(0, 59), bin);
    s.minute_byte = enc($urandom_range(0, 59), bin);
    s.hour_byte = h24 ? enc(h, bin) : (enc(h12, bin) | ((h >= 12) ? 8'h80 : 8'h00));
    s.weekday_byte = enc($urandom_range(1, 7), bin);
    s.day_byte = enc(d, bin);
    s.month_byte = enc(m, bin);
    s.year_byte = enc(y % 100, bin);
    s.century_byte = enc(y / 100, bin);
    return s;
  endfunction

  // a well-formed sample with one fault put in
  function automatic sample_t broken_sample();
    sample_t     s;
    logic [71:0] flat;
    bit          bin;
    bit          h24;
    int unsigned lim;
    int unsigned y;
    s = good_sample();
    bin = s.mode_status[SB_BINARY_BIT];
    h24 = s.mode_status[SB_H24_BIT];
    lim = eff_limit();
    case ($urandom_range(0, 6))
      0: begin
        flat = s;
        flat[8 * $urandom_range(0, 8) +: 8] = 8'($urandom);
        s = flat;
      end
      1: s.mode_status[SB_INHIBIT_BIT] = 1'b1;
      2: s.day_byte = enc($urandom_range(28, 35), bin);
      3: begin
        // just past the limit
        y = ((lim < YEAR_MIN) ? YEAR_MIN : lim) + $urandom_range(1, 40);
        if (bin || y <= YEAR_CAP) begin
          s.year_byte = enc(y % 100, bin);
          s.century_byte = enc(y / 100, bin);
        end
      end
      4: begin
        y = $urandom_range(0, YEAR_MIN - 1);
        s.year_byte = enc(y % 100, bin);
        s.century_byte = enc(y / 100, bin);
      end
      5: begin
        if (h24)
          s.hour_byte = $urandom_range(0, 1) ? (s.hour_byte | 8'h80)
                                             : enc($urandom_range(24, 39), bin);
        else
          s.hour_byte = enc($urandom_range(0, 1) ? 0 : $urandom_range(13, 19), bin) |
                        (8'($urandom_range(0, 1)) << 7);
      end
      default: begin
        case ($urandom_range(0, 2))
          0: s.minute_byte = enc($urandom_range(60, 99), bin);
          1: s.second_byte = enc($urandom_range(60, 99), bin);
          default: s.weekday_byte = enc($urandom_range(0, 1) ? 0 : $urandom_range(8, 9), bin);
        endcase
      end
    endcase
    return s;
  endfunction

  function automatic sample_t noise_sample();
    sample_t     s;
    logic [95:0] w;
    w = {$urandom, $urandom, $urandom};
    s = w[71:0];
    if ($urandom_range(0, 1))
      s.mode_status[SB_INHIBIT_BIT] = 1'b0;
    return s;
  endfunction

  // hold a sample on the port until the block takes it; called and
  // returning at a falling edge
  task automatic send(sample_t s);
    int seen;
    seen = taken_cnt;
    start <= 1'b1;
    sample <= s;
    do @(negedge clk); while (taken_cnt == seen);
  endtask

  task automatic idle_burst(int n);
    start <= 1'b0;
    sample <= noise_sample();   // junk on the port while start is low
    repeat (n) @(negedge clk);
  endtask

  // wait until every owed result is back, then at least the pipeline depth on top
  task automatic drain();
    start <= 1'b0;
    while (tracker.pending() != 0)
      @(negedge clk);
    repeat (8) @(negedge clk);
  endtask

  // max_year only changes with nothing in flight
  task automatic write_limit(logic [13:0] v);
    int seen;
    drain();
    seen = cfg_cnt;
    cfg_valid <= 1'b1;
    cfg_data <= v;
    do @(negedge clk); while (cfg_cnt == seen);
    cfg_valid <= 1'b0;
    cur_limit = v;
    settings_cnt++;
  endtask

  task automatic run_random(int n, int gap_pct);
    int k;
    int kind;
    for (k = 0; k < n; k++) begin
      kind = $urandom_range(0, 99);
      if (kind < 65)
        send(good_sample());
      else if (kind < 90)
        send(broken_sample());
      else
        send(noise_sample());
      if ($urandom_range(0, 99) < gap_pct)
        idle_burst($urandom_range(1, 9));
    end
  endtask

  initial begin
    logic [13:0] limits [8];
    int          p;
    limits = '{14'd16383, 14'd1969, 14'd0, 14'd1970, 14'd9999,
               14'($urandom_range(1970, 9999)), 14'($urandom_range(0, 16383)),
               MAX_YEAR_RST};

    repeat (10) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // directed corners under the reset limit
    // field order: mode, sec, min, hour, weekday, day, month, year, century
    send(sample_t'{MODE_BCD24, 8'h00, 8'h00, 8'h00, 8'h05, 8'h01, 8'h01, 8'h70, 8'h19});
    send(sample_t'{MODE_BCD24, 8'h59, 8'h59, 8'h23, 8'h05, 8'h31, 8'h12, 8'h99, 8'h20});
    send(sample_t'{8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00});
    send(sample_t'{8'hff, 8'hff, 8'hff, 8'hff, 8'hff, 8'hff, 8'hff, 8'hff, 8'hff});
    // update in progress on an otherwise fine sample
    send(sample_t'{M_INH | M_H24, 8'h10, 8'h20, 8'h08, 8'h02, 8'h15, 8'h06, 8'h24, 8'h20});
    // bad bcd digit
    send(sample_t'{MODE_BCD24, 8'h5a, 8'h20, 8'h08, 8'h02, 8'h15, 8'h06, 8'h24, 8'h20});
    // 24-hour mode: pm flag, hour 24
    send(sample_t'{MODE_BCD24, 8'h10, 8'h20, 8'h81, 8'h02, 8'h15, 8'h06, 8'h24, 8'h20});
    send(sample_t'{MODE_BCD24, 8'h10, 8'h20, 8'h24, 8'h02, 8'h15, 8'h06, 8'h24, 8'h20});
    // 12-hour mode: hour 13, midnight, noon, 11 pm
    send(sample_t'{MODE_BCD12, 8'h10, 8'h20, 8'h13, 8'h02, 8'h15, 8'h06, 8'h24, 8'h20});
    send(sample_t'{MODE_BCD12, 8'h10, 8'h20, 8'h12, 8'h02, 8'h15, 8'h06, 8'h24, 8'h20});
    send(sample_t'{MODE_BCD12, 8'h10, 8'h20, 8'h92, 8'h02, 8'h15, 8'h06, 8'h24, 8'h20});
    send(sample_t'{MODE_BCD12, 8'h10, 8'h20, 8'h91, 8'h02, 8'h15, 8'h06, 8'h24, 8'h20});
    // year just below 1970 and just past the limit
    send(sample_t'{MODE_BCD24, 8'h59, 8'h59, 8'h23, 8'h03, 8'h31, 8'h12, 8'h69, 8'h19});
    send(sample_t'{MODE_BCD24, 8'h00, 8'h00, 8'h00, 8'h05, 8'h01, 8'h01, 8'h00, 8'h21});
    // leap day in 2000, none in 2001
    send(sample_t'{MODE_BCD24, 8'h00, 8'h00, 8'h12, 8'h03, 8'h29, 8'h02, 8'h00, 8'h20});
    send(sample_t'{MODE_BCD24, 8'h00, 8'h00, 8'h12, 8'h03, 8'h29, 8'h02, 8'h01, 8'h20});
    // calendar faults: month 0, month 13, day 0, april 31
    send(sample_t'{MODE_BCD24, 8'h00, 8'h00, 8'h12, 8'h03, 8'h10, 8'h00, 8'h30, 8'h20});
    send(sample_t'{MODE_BCD24, 8'h00, 8'h00, 8'h12, 8'h03, 8'h10, 8'h13, 8'h30, 8'h20});
    send(sample_t'{MODE_BCD24, 8'h00, 8'h00, 8'h12, 8'h03, 8'h00, 8'h05, 8'h30, 8'h20});
    send(sample_t'{MODE_BCD24, 8'h00, 8'h00, 8'h12, 8'h03, 8'h31, 8'h04, 8'h30, 8'h20});
    // minute 60, second 60, weekday 0, weekday 8
    send(sample_t'{MODE_BCD24, 8'h00, 8'h60, 8'h12, 8'h03, 8'h10, 8'h05, 8'h30, 8'h20});
    send(sample_t'{MODE_BCD24, 8'h60, 8'h00, 8'h12, 8'h03, 8'h10, 8'h05, 8'h30, 8'h20});
    send(sample_t'{MODE_BCD24, 8'h00, 8'h00, 8'h12, 8'h00, 8'h10, 8'h05, 8'h30, 8'h20});
    send(sample_t'{MODE_BCD24, 8'h00, 8'h00, 8'h12, 8'h08, 8'h10, 8'h05, 8'h30, 8'h20});
    // binary mode with the largest year the bytes can form
    send(sample_t'{MODE_BIN24, 8'hff, 8'hff, 8'h17, 8'hff, 8'hff, 8'hff, 8'hff, 8'hff});

    run_random(PHASE_ITEMS, 15);

    for (p = 0; p < 8; p++) begin
      write_limit(limits[p]);
      if (p == 0) begin
        // limit above the cap: last second of 9999, 2100 is no leap year, 2400 is
        send(sample_t'{MODE_BCD24, 8'h59, 8'h59, 8'h23, 8'h06, 8'h31, 8'h12, 8'h99, 8'h99});
        send(sample_t'{MODE_BCD24, 8'h00, 8'h00, 8'h00, 8'h01, 8'h29, 8'h02, 8'h00, 8'h21});
        send(sample_t'{MODE_BCD24, 8'h00, 8'h00, 8'h00, 8'h02, 8'h29, 8'h02, 8'h00, 8'h24});
      end
      // the closing phase runs back to back with no gaps
      run_random(PHASE_ITEMS, (p == 7) ? 0 : 20 * $urandom_range(0, 2));
    end

    drain();
    $display("checked %0d samples under %0d max_year settings", tracker.samples_seen,
             settings_cnt);
    $display("outcomes: %0d ok, %0d invalid, %0d year out of range", tracker.n_ok,
             tracker.n_invalid, tracker.n_range);
    if (tracker.errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("%0d bad results", tracker.errors);
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
